[sv/brf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the bisection root finder.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int ITER_W         = 16;
  localparam int TOL_W          = 31;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 31;

  localparam logic [TOL_W-1:0]  TOL_RESET        = 31'd66;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 16'd64;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'd1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_VALUE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_A   = 2'd1,
    PH_WAIT_B   = 2'd2,
    PH_WAIT_MID = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_EVAL    = 2'd0,
    KIND_ROOT    = 2'd1,
    KIND_FAIL    = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t              phase;
    logic [ITER_W-1:0]   step_count;
  } brf_ctl_t;

  typedef struct packed {
    kind_t               kind;
    logic [ITER_W-1:0]   iterations;
  } brf_res_t;

endpackage
`default_nettype wire

[sv/brf_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_step
// One search step: next search state and the result for one transaction.
// ----------------------------------------------------------------------------
module brf_step #(
  parameter int WORD_WIDTH = brf_pkg::WORD_WIDTH_DEF
) (
  input  logic                        cmd,
  input  logic [WORD_WIDTH-1:0]       left_bound,
  input  logic [WORD_WIDTH-1:0]       right_bound,
  input  logic [WORD_WIDTH-1:0]       func_value,
  input  logic [brf_pkg::TOL_W-1:0]   tolerance,
  input  logic [brf_pkg::ITER_W-1:0]  iteration_limit,
  input  brf_pkg::brf_ctl_t           ctl,
  input  logic [WORD_WIDTH-1:0]       low_end,
  input  logic [WORD_WIDTH-1:0]       high_end,
  input  logic [WORD_WIDTH-1:0]       low_value,
  input  logic [WORD_WIDTH-1:0]       high_value,
  input  logic [WORD_WIDTH-1:0]       midpoint,
  output brf_pkg::brf_ctl_t           ctl_nxt,
  output logic [WORD_WIDTH-1:0]       low_end_nxt,
  output logic [WORD_WIDTH-1:0]       high_end_nxt,
  output logic [WORD_WIDTH-1:0]       low_value_nxt,
  output logic [WORD_WIDTH-1:0]       high_value_nxt,
  output logic [WORD_WIDTH-1:0]       midpoint_nxt,
  output brf_pkg::brf_res_t           res,
  output logic [WORD_WIDTH-1:0]       point
);
  import brf_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int CW = (W - 1 > TOL_W) ? W - 1 : TOL_W;

  // saturated magnitude
  function automatic logic [W-2:0] sat_abs(input logic [W-1:0] x);
    logic [W-1:0] m;
    m = x[W-1] ? (~x + 1'b1) : x;
    sat_abs = m[W-1] ? {(W-1){1'b1}} : m[W-2:0];
  endfunction

  function automatic logic opposite(input logic [W-1:0] x, input logic [W-1:0] y);
    logic x_pos;
    logic y_pos;
    x_pos = !x[W-1] && (|x);
    y_pos = !y[W-1] && (|y);
    opposite = (x_pos && y[W-1]) || (x[W-1] && y_pos);
  endfunction

  // floor((x + y) / 2) without overflow
  function automatic logic [W-1:0] floor_mid(input logic [W-1:0] x, input logic [W-1:0] y);
    floor_mid = {x[W-1], x[W-1:1]} + {y[W-1], y[W-1:1]} + W'(x[0] & y[0]);
  endfunction

  function automatic logic [W-2:0] width_sat(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] xe;
    logic [W:0] ye;
    logic [W:0] d;
    xe = {x[W-1], x};
    ye = {y[W-1], y};
    d  = ($signed(xe) < $signed(ye)) ? (ye - xe) : (xe - ye);
    width_sat = (|d[W:W-1]) ? {(W-1){1'b1}} : d[W-2:0];
  endfunction

  logic              fv_small;
  logic              lv_fv_opp;
  logic              hv_fv_opp;
  logic              lo_mid_sel;
  logic              hi_mid_sel;
  logic [W-1:0]      lo_e_upd;
  logic [W-1:0]      hi_e_upd;
  logic              narrow;
  logic [ITER_W-1:0] step_inc;
  logic              limit_hit;
  logic              limit_zero;
  logic [W-1:0]      mid_start;
  logic [W-1:0]      mid_next;
  phase_t            phase_nxt;
  logic [ITER_W-1:0] step_count_nxt;

  assign fv_small   = CW'(sat_abs(func_value)) < CW'(tolerance);
  assign lv_fv_opp  = opposite(low_value, func_value);
  assign hv_fv_opp  = opposite(high_value, func_value);
  assign hi_mid_sel = lv_fv_opp;
  assign lo_mid_sel = !lv_fv_opp && hv_fv_opp;
  assign lo_e_upd   = lo_mid_sel ? midpoint : low_end;
  assign hi_e_upd   = hi_mid_sel ? midpoint : high_end;
  assign narrow     = CW'(width_sat(lo_e_upd, hi_e_upd)) < CW'(tolerance);
  assign step_inc   = ctl.step_count + 1'b1;
  assign limit_hit  = step_inc >= iteration_limit;
  assign limit_zero = iteration_limit == '0;
  assign mid_start  = floor_mid(low_end, high_end);
  assign mid_next   = floor_mid(lo_e_upd, hi_e_upd);

  assign ctl_nxt = '{phase: phase_nxt, step_count: step_count_nxt};

  // next phase
  always_comb begin
    phase_nxt = ctl.phase;
    if (cmd == CMD_START) begin
      phase_nxt = PH_WAIT_A;
    end else begin
      unique case (ctl.phase)
        PH_WAIT_A: begin
          phase_nxt = fv_small ? PH_IDLE : PH_WAIT_B;
        end
        PH_WAIT_B: begin
          phase_nxt = (fv_small || !lv_fv_opp || limit_zero) ? PH_IDLE : PH_WAIT_MID;
        end
        PH_WAIT_MID: begin
          phase_nxt = (fv_small || narrow || limit_hit) ? PH_IDLE : PH_WAIT_MID;
        end
        PH_IDLE: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // datapath and result
  always_comb begin
    step_count_nxt = ctl.step_count;
    low_end_nxt    = low_end;
    high_end_nxt   = high_end;
    low_value_nxt  = low_value;
    high_value_nxt = high_value;
    midpoint_nxt   = midpoint;
    res.kind       = KIND_IGNORED;
    res.iterations = '0;
    point          = '0;
    if (cmd == CMD_START) begin
      low_end_nxt    = left_bound;
      high_end_nxt   = right_bound;
      step_count_nxt = '0;
      res.kind       = KIND_EVAL;
      point          = left_bound;
    end else begin
      unique case (ctl.phase)
        PH_WAIT_A: begin
          low_value_nxt = func_value;
          res.kind      = fv_small ? KIND_ROOT : KIND_EVAL;
          point         = fv_small ? low_end : high_end;
        end
        PH_WAIT_B: begin
          high_value_nxt = func_value;
          priority if (fv_small) begin
            res.kind = KIND_ROOT;
            point    = high_end;
          end else if (!lv_fv_opp || limit_zero) begin
            res.kind = KIND_FAIL;
          end else begin
            step_count_nxt = '0;
            midpoint_nxt   = mid_start;
            res.kind       = KIND_EVAL;
            point          = mid_start;
          end
        end
        PH_WAIT_MID: begin
          if (fv_small) begin
            res.kind       = KIND_ROOT;
            res.iterations = ctl.step_count;
            point          = midpoint;
          end else begin
            low_end_nxt  = lo_e_upd;
            high_end_nxt = hi_e_upd;
            if (lo_mid_sel) begin
              low_value_nxt = func_value;
            end
            if (hi_mid_sel) begin
              high_value_nxt = func_value;
            end
            priority if (narrow) begin
              res.kind       = KIND_ROOT;
              res.iterations = ctl.step_count;
              point          = midpoint;
            end else if (limit_hit) begin
              step_count_nxt = step_inc;
              res.kind       = KIND_FAIL;
            end else begin
              step_count_nxt = step_inc;
              midpoint_nxt   = mid_next;
              res.kind       = KIND_EVAL;
              point          = mid_next;
            end
          end
        end
        PH_IDLE: begin
          res.kind = KIND_IGNORED;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/bisection_root_finder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisection_root_finder_top
// Bisection root finder in signed Q16.16 that drives an external evaluator.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction: a start
// (command 0) asks for f at the left bound; each returned value (command 1)
// yields the next point to evaluate, the root with its iteration index, a
// failure, or an ignored result while no search runs. An input transaction
// is registered, then the step logic updates the search state and loads the
// output register; one transaction is taken every cycle while the output
// side keeps up. In a search loop the round trip through the external
// evaluator sets the pace, since each value answers the previous request.
// The user must write tolerance and iteration limit through the cfg port
// only while no search transaction is in flight; the block does not check.
module bisection_root_finder_top #(
  parameter int WORD_WIDTH = brf_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [WORD_WIDTH-1:0]         in_left_bound,
  input  logic [WORD_WIDTH-1:0]         in_right_bound,
  input  logic [WORD_WIDTH-1:0]         in_func_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output brf_pkg::kind_t                out_kind,
  output logic [WORD_WIDTH-1:0]         out_point,
  output logic [brf_pkg::ITER_W-1:0]    out_iterations,
  input  logic                          cfg_we,
  input  logic [brf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import brf_pkg::*;

  localparam int W = WORD_WIDTH;

  logic [TOL_W-1:0]  tolerance_r;
  logic [ITER_W-1:0] iter_limit_r;

  logic              in_valid_r;
  logic              cmd_r;
  logic [W-1:0]      left_r;
  logic [W-1:0]      right_r;
  logic [W-1:0]      fv_r;

  brf_ctl_t          ctl_r;
  logic [W-1:0]      low_end_r;
  logic [W-1:0]      high_end_r;
  logic [W-1:0]      low_value_r;
  logic [W-1:0]      high_value_r;
  logic [W-1:0]      midpoint_r;

  brf_ctl_t          ctl_nxt;
  logic [W-1:0]      low_end_nxt;
  logic [W-1:0]      high_end_nxt;
  logic [W-1:0]      low_value_nxt;
  logic [W-1:0]      high_value_nxt;
  logic [W-1:0]      midpoint_nxt;
  brf_res_t          res_nxt;
  logic [W-1:0]      point_nxt;

  logic              out_valid_r;
  brf_res_t          res_r;
  logic [W-1:0]      point_r;

  logic              advance;
  logic              in_take;
  logic              step_fire;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign step_fire = in_valid_r && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= TOL_RESET;
      iter_limit_r <= ITER_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE:  tolerance_r  <= cfg_wdata[TOL_W-1:0];
        REG_ITER_LIMIT: iter_limit_r <= cfg_wdata[ITER_W-1:0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r   <= in_command;
      left_r  <= in_left_bound;
      right_r <= in_right_bound;
      fv_r    <= in_func_value;
    end
  end

  brf_step #(
    .WORD_WIDTH(W)
  ) u_step (
    .cmd             (cmd_r),
    .left_bound      (left_r),
    .right_bound     (right_r),
    .func_value      (fv_r),
    .tolerance       (tolerance_r),
    .iteration_limit (iter_limit_r),
    .ctl             (ctl_r),
    .low_end         (low_end_r),
    .high_end        (high_end_r),
    .low_value       (low_value_r),
    .high_value      (high_value_r),
    .midpoint        (midpoint_r),
    .ctl_nxt         (ctl_nxt),
    .low_end_nxt     (low_end_nxt),
    .high_end_nxt    (high_end_nxt),
    .low_value_nxt   (low_value_nxt),
    .high_value_nxt  (high_value_nxt),
    .midpoint_nxt    (midpoint_nxt),
    .res             (res_nxt),
    .point           (point_nxt)
  );

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= PH_IDLE;
      ctl_r.step_count <= '0;
      low_end_r        <= '0;
      high_end_r       <= '0;
      low_value_r      <= '0;
      high_value_r     <= '0;
      midpoint_r       <= '0;
    end else if (step_fire) begin
      ctl_r        <= ctl_nxt;
      low_end_r    <= low_end_nxt;
      high_end_r   <= high_end_nxt;
      low_value_r  <= low_value_nxt;
      high_value_r <= high_value_nxt;
      midpoint_r   <= midpoint_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_r   <= res_nxt;
      point_r <= point_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_iterations = res_r.iterations;
  assign out_point      = point_r;

endmodule
`default_nettype wire

[sv/brf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks of the bisection root finder, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker #(
  parameter int WORD_WIDTH = brf_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  brf_pkg::kind_t               out_kind,
  input  logic [WORD_WIDTH-1:0]        out_point,
  input  logic [brf_pkg::ITER_W-1:0]   out_iterations
);
  import brf_pkg::*;

  // no result transaction right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_point) && $stable(out_iterations))
    else $error("stalled result changed");

  // input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // failure and ignored results carry no point and no count
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FAIL || out_kind == KIND_IGNORED) |->
      out_point == '0 && out_iterations == '0)
    else $error("failure or ignored result with nonzero fields");

  // only a root reports an iteration count
  a_iter_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EVAL |-> out_iterations == '0)
    else $error("evaluate request with nonzero iteration count");

endmodule

bind bisection_root_finder_top brf_checker #(
  .WORD_WIDTH(WORD_WIDTH)
) u_brf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_point      (out_point),
  .out_iterations (out_iterations)
);
`default_nettype wire
